FILE: sv/dtsp_pkg.sv
// Shared types and constants for the DER TLV stream parser.
package dtsp_pkg;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned HDR_W  = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned LBL_W  = 3;
  localparam int unsigned CNT_W  = 7;

  // Encoding constants.
  localparam logic [BYTE_W-1:0] TAG_MULTI_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEN_LONG_BIT   = 8'h80;
  localparam logic [CNT_W-1:0]  LEN_COUNT_MASK = 7'h7F;
  localparam logic [CNT_W-1:0]  MAX_LEN_BYTES  = 7'd4;
  localparam logic [HDR_W-1:0]  HDR_SHORT      = 3'd2;
  localparam logic [HDR_W-1:0]  HDR_TAG_ONLY   = 3'd1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MULTI_TAG  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_INDEFINITE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_LEN_LONG   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OVERRUN    = 3'd5;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_LEN,
    PH_LENX,
    PH_CONTENT,
    PH_DROP
  } phase_t;

  // One result beat.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] tag;
    logic [LEN_W-1:0]  content_length;
    logic [HDR_W-1:0]  header_length;
    logic [BYTE_W-1:0] content_byte;
    logic              content_last;
    logic              buffer_end;
    logic [ERR_W-1:0]  error_code;
  } result_t;

  // One input beat.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic [LEN_W-1:0]  buffer_length;
  } beat_t;

endpackage

FILE: sv/dtsp_core.sv
// Parser state registers and the per-byte step logic.
module dtsp_core
  import dtsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  beat_t   beat,
  output logic    res_valid,
  output result_t res
);

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] tag_r, tag_nxt;
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [LBL_W-1:0]  lbl_r, lbl_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [LEN_W-1:0]  cl_r, cl_nxt;

  phase_t            ph_eff;
  logic [LEN_W-1:0]  rem_eff;
  logic [LEN_W-1:0]  after;
  logic              bend;
  logic              active;
  logic              hdr_done;
  logic [ERR_W-1:0]  err;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] b;

  assign b   = beat.data_byte;
  assign cnt = b[CNT_W-1:0] & LEN_COUNT_MASK;

  // Step logic: one byte updates the state and yields at most one result.
  always_comb begin
    ph_eff    = phase_r;
    rem_eff   = rem_r;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    lbl_nxt   = lbl_r;
    hdr_nxt   = hdr_r;
    cl_nxt    = cl_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    hdr_done  = 1'b0;
    err       = ERR_NONE;
    res_valid = 1'b0;
    res       = '0;

    // A first byte restarts the parser with a fresh buffer count.
    if (beat.first_byte) begin
      ph_eff    = PH_TAG;
      rem_eff   = beat.buffer_length;
      tag_nxt   = '0;
      acc_nxt   = '0;
      lbl_nxt   = '0;
      hdr_nxt   = '0;
      cl_nxt    = '0;
      phase_nxt = PH_TAG;
    end

    active = (ph_eff == PH_TAG) || (ph_eff == PH_LEN) ||
             (ph_eff == PH_LENX) || (ph_eff == PH_CONTENT);
    after  = (rem_eff != '0) ? rem_eff - LEN_W'(1) : '0;
    bend   = (rem_eff <= LEN_W'(1));

    unique case (ph_eff) inside
      PH_TAG: begin
        tag_nxt = b;
        hdr_nxt = HDR_TAG_ONLY;
        acc_nxt = '0;
        lbl_nxt = '0;
        cl_nxt  = '0;
        if (rem_eff < LEN_W'(2)) begin
          err = ERR_SHORT;
        end else if ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK) begin
          err = ERR_MULTI_TAG;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        hdr_nxt = HDR_SHORT;
        if (b < LEN_LONG_BIT) begin
          acc_nxt  = LEN_W'(b);
          hdr_done = 1'b1;
        end else if (b == LEN_LONG_BIT) begin
          err = ERR_INDEFINITE;
        end else if (cnt > MAX_LEN_BYTES) begin
          err = ERR_LEN_LONG;
        end else if (LEN_W'(cnt) > after) begin
          err = ERR_SHORT;
        end else begin
          lbl_nxt   = LBL_W'(cnt);
          acc_nxt   = '0;
          phase_nxt = PH_LENX;
        end
      end
      PH_LENX: begin
        acc_nxt = {acc_r[LEN_W-BYTE_W-1:0], b};
        hdr_nxt = hdr_r + HDR_W'(1);
        lbl_nxt = (lbl_r != '0) ? lbl_r - LBL_W'(1) : '0;
        if (lbl_nxt == '0) begin
          hdr_done = 1'b1;
        end
      end
      PH_CONTENT: begin
        cl_nxt                 = (cl_r != '0) ? cl_r - LEN_W'(1) : '0;
        res_valid              = 1'b1;
        res.kind               = KIND_CONTENT;
        res.tag                = tag_r;
        res.content_length     = acc_r;
        res.header_length      = hdr_r;
        res.content_byte       = b;
        res.content_last       = (cl_nxt == '0);
        res.buffer_end         = bend;
        if (cl_nxt == '0) begin
          phase_nxt = PH_TAG;
        end
      end
      PH_IDLE, PH_DROP: begin
      end
      default: begin
      end
    endcase

    // Header complete: check that the content fits in the rest of the buffer.
    if (hdr_done) begin
      if (acc_nxt > after) begin
        err = ERR_OVERRUN;
      end else begin
        res_valid          = 1'b1;
        res.kind           = KIND_HEADER;
        res.tag            = tag_nxt;
        res.content_length = acc_nxt;
        res.header_length  = hdr_nxt;
        res.buffer_end     = bend;
        cl_nxt             = acc_nxt;
        phase_nxt          = (acc_nxt != '0) ? PH_CONTENT : PH_TAG;
      end
    end

    // Any fault gives one error beat and drops the rest of the buffer.
    if (err != ERR_NONE) begin
      res_valid  = 1'b1;
      res        = '0;
      res.kind   = KIND_ERROR;
      res.tag    = tag_nxt;
      res.buffer_end = bend;
      res.error_code = err;
      if (err == ERR_OVERRUN) begin
        res.content_length = acc_nxt;
        res.header_length  = hdr_nxt;
      end
      phase_nxt = PH_DROP;
    end

    // Count the byte off the buffer; the last byte ends it.
    if (active) begin
      rem_nxt = after;
      if (after == '0) begin
        phase_nxt = PH_IDLE;
      end
    end else begin
      res_valid = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rem_r   <= '0;
      tag_r   <= '0;
      acc_r   <= '0;
      lbl_r   <= '0;
      hdr_r   <= '0;
      cl_r    <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      tag_r   <= tag_nxt;
      acc_r   <= acc_nxt;
      lbl_r   <= lbl_nxt;
      hdr_r   <= hdr_nxt;
      cl_r    <= cl_nxt;
    end
  end

endmodule

FILE: sv/der_tlv_stream_parser.sv
// Top level of the DER TLV stream parser: input register, step logic, result register.
// A byte accepted into the input register steps into the result register, which
// shows its result beat; bytes that give no result simply pass through the input register.
// Throughput: one byte per cycle, limited only by out_ready through the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle,
// where it waits for a byte with first_byte set.
module der_tlv_stream_parser
  import dtsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_first_byte,
  input  logic [LEN_W-1:0]  in_buffer_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_tag,
  output logic [LEN_W-1:0]  out_content_length,
  output logic [HDR_W-1:0]  out_header_length,
  output logic [BYTE_W-1:0] out_content_byte,
  output logic              out_content_last,
  output logic              out_buffer_end,
  output logic [ERR_W-1:0]  out_error_code
);

  logic    in_valid_r;
  beat_t   in_beat_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  logic    res_valid;
  result_t res;

  // The held byte steps once the result register can take its beat.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_beat_r <= '{data_byte: in_data_byte, first_byte: in_first_byte,
                     buffer_length: in_buffer_length};
    end
  end

  // Step logic and parser state.
  dtsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .beat      (in_beat_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_tag            = out_res_r.tag;
  assign out_content_length = out_res_r.content_length;
  assign out_header_length  = out_res_r.header_length;
  assign out_content_byte   = out_res_r.content_byte;
  assign out_content_last   = out_res_r.content_last;
  assign out_buffer_end     = out_res_r.buffer_end;
  assign out_error_code     = out_res_r.error_code;

endmodule
